/* sv/conveyor_soft_start_sorter_macros.svh */
// Assertion macros shared by the checker of the conveyor soft-start sorter.
`ifndef CONVEYOR_SOFT_START_SORTER_MACROS_SVH
`define CONVEYOR_SOFT_START_SORTER_MACROS_SVH

// An antecedent that holds in a cycle implies the consequent in the same cycle.
`define CSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// An antecedent that holds in a cycle implies the consequent in the next cycle.
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* sv/css_pkg.sv */
package css_pkg;

   // Width of the saturating millisecond age counters.
   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS   = 16;
   // Width in which an age is compared with a configured limit.
   localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIPE     = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] RAMP_RESET     = 16'd10;
   localparam logic [7:0]  TOP_RESET      = 8'd255;
   localparam logic [7:0]  GREEN_RESET    = 8'd0;
   localparam logic [7:0]  RIPE_RESET     = 8'd60;

   // Command characters.
   localparam logic [7:0] CMD_NONE  = 8'h00;
   localparam logic [7:0] CMD_STOP  = 8'h45; // E
   localparam logic [7:0] CMD_START = 8'h49; // I
   localparam logic [7:0] CMD_BRAKE = 8'h46; // F
   localparam logic [7:0] CMD_RIPE  = 8'h4D; // M
   localparam logic [7:0] CMD_GREEN = 8'h56; // V

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_OPER  = 2'd2,
      PH_BRAKE = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_START = 3'd1,
      EV_BRAKE = 3'd2,
      EV_RIPE  = 3'd3,
      EV_GREEN = 3'd4
   } event_type;

   typedef struct packed {
      logic       emergency;
      logic       serial_valid;
      logic [7:0] serial_byte;
      logic       btn_start;
      logic       btn_brake;
      logic       btn_ripe;
      logic       btn_green;
   } req_type;

   typedef struct packed {
      logic [7:0] motor_duty;
      logic [7:0] servo_angle;
      logic [1:0] run_state;
      logic [2:0] button_event;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] ramp_interval_ms;
      logic [7:0]  top_speed;
      logic [7:0]  angle_green;
      logic [7:0]  angle_ripe;
   } cfg_type;

endpackage

/* sv/css_cfg.sv */
module css_cfg
   import css_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms      = wr_data;
            CSR_RAMP:     cfg_in.ramp_interval_ms = wr_data;
            CSR_TOP:      cfg_in.top_speed        = wr_data[7:0];
            CSR_GREEN:    cfg_in.angle_green      = wr_data[7:0];
            CSR_RIPE:     cfg_in.angle_ripe       = wr_data[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_RESET;
         cfg_ff.ramp_interval_ms <= RAMP_RESET;
         cfg_ff.top_speed        <= TOP_RESET;
         cfg_ff.angle_green      <= GREEN_RESET;
         cfg_ff.angle_ripe       <= RIPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/css_ctrl.sv */
module css_ctrl
   import css_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp_in
);

   phase_type             phase_ff, phase_in;
   logic [7:0]            speed_ff, speed_in;
   logic                  ripe_ff, ripe_in;
   logic [3:0]            prev_ff, prev_in;
   logic [TIMER_BITS-1:0] dage_ff, dage_in;
   logic [TIMER_BITS-1:0] rage_ff, rage_in;

   logic [TIMER_BITS-1:0] dage_sat, rage_sat;
   logic [3:0]            levels, falls;
   logic                  have_byte;
   logic [7:0]            cmd;
   event_type             event_code;

   always_comb begin
      dage_sat = (&dage_ff) ? dage_ff : dage_ff + 1'b1;
      rage_sat = (&rage_ff) ? rage_ff : rage_ff + 1'b1;
      levels   = {req.btn_green, req.btn_ripe, req.btn_brake, req.btn_start};
      falls    = prev_ff & ~levels;

      phase_in   = phase_ff;
      speed_in   = speed_ff;
      ripe_in    = ripe_ff;
      prev_in    = prev_ff;
      dage_in    = dage_sat;
      rage_in    = rage_sat;
      cmd        = CMD_NONE;
      event_code = EV_NONE;
      have_byte  = req.serial_valid && !req.emergency;

      if (req.emergency) begin
         phase_in = PH_WAIT;
         speed_in = '0;
         ripe_in  = 1'b0;
      end

      if (have_byte) begin
         cmd = req.serial_byte;
      end else begin
         if (CMP_BITS'(dage_sat) > CMP_BITS'(cfg.debounce_ms)) begin
            if (falls[0]) begin
               cmd = CMD_START; event_code = EV_START; dage_in = '0;
            end else if (falls[1]) begin
               cmd = CMD_BRAKE; event_code = EV_BRAKE; dage_in = '0;
            end else if (falls[2]) begin
               cmd = CMD_RIPE;  event_code = EV_RIPE;  dage_in = '0;
            end else if (falls[3]) begin
               cmd = CMD_GREEN; event_code = EV_GREEN; dage_in = '0;
            end
         end
         prev_in = levels;
      end

      if (cmd == CMD_STOP) begin
         phase_in = PH_WAIT;
         speed_in = '0;
         ripe_in  = 1'b0;
      end else if (phase_in == PH_WAIT && cmd == CMD_START) begin
         phase_in = PH_ACCEL;
      end else if (phase_in == PH_OPER && cmd == CMD_BRAKE) begin
         phase_in = PH_BRAKE;
      end else if (phase_in == PH_OPER) begin
         if (cmd == CMD_RIPE) begin
            ripe_in = 1'b1;
         end else if (cmd == CMD_GREEN) begin
            ripe_in = 1'b0;
         end
      end

      if (CMP_BITS'(rage_sat) > CMP_BITS'(cfg.ramp_interval_ms)) begin
         rage_in = '0;
         if (phase_in == PH_ACCEL) begin
            if (speed_in < cfg.top_speed) begin
               speed_in = speed_in + 8'd1;
            end else begin
               phase_in = PH_OPER;
            end
         end else if (phase_in == PH_BRAKE) begin
            if (speed_in != 8'd0) begin
               speed_in = speed_in - 8'd1;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      end

      rsp_in.motor_duty   = speed_in;
      rsp_in.servo_angle  = ripe_in ? cfg.angle_ripe : cfg.angle_green;
      rsp_in.run_state    = phase_in;
      rsp_in.button_event = event_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         speed_ff <= '0;
         ripe_ff  <= 1'b0;
         prev_ff  <= '1;
         dage_ff  <= '0;
         rage_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         speed_ff <= speed_in;
         ripe_ff  <= ripe_in;
         prev_ff  <= prev_in;
         dage_ff  <= dage_in;
         rage_ff  <= rage_in;
      end
   end

endmodule

/* sv/conveyor_soft_start_sorter.sv */
// Channel   Direction  Handshake              Word
// req_      in         req_valid / req_ready  req_data: one millisecond tick
// rsp_      out        rsp_valid / rsp_ready  rsp_data: duty, angle, state, event
// csr_      in         csr_valid / csr_ready  csr_index, csr_data: register write
//
// One tick word is taken in every clock cycle while the result register is free
// or being emptied; its result word is shown in the cycle after it is taken. The
// controller state and the result register change together at the accepting edge.
// Reset is synchronous and active high; it restores the configuration and state
// registers to their documented values and empties the result register, and while
// it is high no word is taken on either input channel. A stalled result holds
// req_ready low, which stalls the tick stream; out of reset csr_ready is always high.
module conveyor_soft_start_sorter
   import css_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type cfg;
   rsp_type rsp_in;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    req_accept;

   // Configuration writes are taken whenever the block is out of reset; writes to
   // an unused index are dropped.
   assign csr_ready = !reset;

   css_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // A new tick may enter whenever the result register is empty or is being
   // emptied in this same cycle, but never while reset is held.
   assign req_ready  = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   // The controller works out the whole tick in one pass and commits its
   // state on the accepting edge.
   css_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (req_accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp_in (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset: it is only looked at while valid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/css_checker.sv */
`include "conveyor_soft_start_sorter_macros.svh"

module css_checker
   import css_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result word stays put.
   `CSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Every accepted tick produces a result word in the following cycle.
   `CSS_ASSERT_NEXT(a_tick_gives_word, clock, reset, req_valid && req_ready, rsp_valid)

   // The motor is always at rest while the belt is waiting.
   `CSS_ASSERT_SAME(a_wait_means_still, clock, reset, rsp_valid && rsp_data.run_state == PH_WAIT, rsp_data.motor_duty == 8'd0)

   // Only the four button codes or none are ever reported.
   `CSS_ASSERT_SAME(a_event_range, clock, reset, rsp_valid, rsp_data.button_event <= EV_GREEN)

endmodule

bind conveyor_soft_start_sorter css_checker u_css_checker (.*);

/* verif/tb_conveyor_soft_start_sorter.sv */
module tb_conveyor_soft_start_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   import css_pkg::*;

   // The age counters stop at their top value rather than wrapping.
   localparam logic [TIMER_BITS-1:0] AGE_LIMIT = '1;
   // Indexes above the last register are accepted by the port but change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = CSR_RIPE + 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = '1;
   localparam int RANDOM_TICKS    = 1700;
   localparam int PRESSURE_CYCLES = 300;
   localparam int IDLE_SPAN_CAP   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   conveyor_soft_start_sorter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Tick words waiting to be offered, and the result words they are predicted to give.
   req_type pending_ticks[$];
   rsp_type expected_results[$];

   // Our own copy of the controller state, updated once per accepted tick word.
   phase_type             belt_phase;
   logic [7:0]            belt_speed;
   logic                  servo_ripe;
   logic [3:0]            last_levels;
   logic [TIMER_BITS-1:0] debounce_age;
   logic [TIMER_BITS-1:0] ramp_age;

   // Our own copy of the configuration registers.
   logic [15:0] lim_debounce;
   logic [15:0] lim_ramp;
   logic [7:0]  speed_top;
   logic [7:0]  green_angle;
   logic [7:0]  ripe_angle;

   // Handshake bookkeeping of the clocked processes.
   logic        req_fire = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned hold_left = 0;
   logic        req_idle_on = 1'b0;
   logic        rsp_idle_on = 1'b0;
   logic        pressure_start = 1'b0;
   logic        pressure_done = 1'b0;

   // Stimulus generator state: the button levels currently held down (0 pressed).
   logic [3:0]  held_levels = '1;
   int unsigned idle_span = 8;

   int unsigned fail_count = 0;
   int unsigned ticks_queued = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned events_taken = 0;
   logic [3:0]  states_seen = '0;
   logic [7:0]  top_duty = '0;

   // Gap lengths drawn from three ranges: mostly the shortest, now and then the longest.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 10);
      return $urandom_range(15, 40);
   endfunction

   // One millisecond of the controller: ages, emergency, command capture, command and
   // ramp step in that order, returning the result word of the tick.
   function automatic rsp_type advance_belt(req_type t);
      rsp_type    r;
      logic [7:0] cmd;
      logic [3:0] levels;
      logic       take_byte;
      event_type  ev;
      int         b;
      cmd       = CMD_NONE;
      ev        = EV_NONE;
      levels    = {t.btn_green, t.btn_ripe, t.btn_brake, t.btn_start};
      take_byte = t.serial_valid;
      if (debounce_age != AGE_LIMIT)
         debounce_age++;
      if (ramp_age != AGE_LIMIT)
         ramp_age++;

      // An emergency wins over everything, and the serial byte of the tick is lost.
      if (t.emergency) begin
         belt_speed = '0;
         belt_phase = PH_WAIT;
         servo_ripe = 1'b0;
         take_byte  = 1'b0;
      end

      if (take_byte) begin
         cmd = t.serial_byte;
      end else begin
         // The first falling edge in priority order is taken, and only once the
         // lockout since the previous button command has run out.
         if (debounce_age > lim_debounce) begin
            for (b = 0; b < 4; b++) begin
               if (ev == EV_NONE && !levels[b] && last_levels[b]) begin
                  ev           = event_type'(b + 1);
                  debounce_age = '0;
               end
            end
         end
         last_levels = levels;
      end
      case (ev)
         EV_START: cmd = CMD_START;
         EV_BRAKE: cmd = CMD_BRAKE;
         EV_RIPE:  cmd = CMD_RIPE;
         EV_GREEN: cmd = CMD_GREEN;
         default:  ;
      endcase

      if (cmd == CMD_STOP) begin
         belt_phase = PH_WAIT;
         belt_speed = '0;
         servo_ripe = 1'b0;
      end else if (belt_phase == PH_WAIT && cmd == CMD_START) begin
         belt_phase = PH_ACCEL;
      end else if (belt_phase == PH_OPER && cmd == CMD_BRAKE) begin
         belt_phase = PH_BRAKE;
      end else if (belt_phase == PH_OPER && cmd == CMD_RIPE) begin
         servo_ripe = 1'b1;
      end else if (belt_phase == PH_OPER && cmd == CMD_GREEN) begin
         servo_ripe = 1'b0;
      end

      // The phase only moves on in the step after the end value was reached.
      if (ramp_age > lim_ramp) begin
         ramp_age = '0;
         if (belt_phase == PH_ACCEL) begin
            if (belt_speed < speed_top)
               belt_speed++;
            else
               belt_phase = PH_OPER;
         end else if (belt_phase == PH_BRAKE) begin
            if (belt_speed != '0)
               belt_speed--;
            else
               belt_phase = PH_WAIT;
         end
      end

      r.motor_duty   = belt_speed;
      r.servo_angle  = servo_ripe ? ripe_angle : green_angle;
      r.run_state    = belt_phase;
      r.button_event = ev;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Sampling side. Everything the block shows is read at the rising edge, so the
   // block's own updates at that edge are not yet visible here.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fire     = 1'b0;
         belt_phase   = PH_WAIT;
         belt_speed   = '0;
         servo_ripe   = 1'b0;
         last_levels  = '1;
         debounce_age = '0;
         ramp_age     = '0;
         lim_debounce = DEBOUNCE_RESET;
         lim_ramp     = RAMP_RESET;
         speed_top    = TOP_RESET;
         green_angle  = GREEN_RESET;
         ripe_angle   = RIPE_RESET;
      end else begin
         req_fire = req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result word arrived with no tick word outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("motor_duty", want.motor_duty, rsp_data.motor_duty);
               check_field("servo_angle", want.servo_angle, rsp_data.servo_angle);
               check_field("run_state", {6'd0, want.run_state},
                           {6'd0, rsp_data.run_state});
               check_field("button_event", {5'd0, want.button_event},
                           {5'd0, rsp_data.button_event});
               results_checked++;
               states_seen[want.run_state] = 1'b1;
               if (want.button_event != EV_NONE)
                  events_taken++;
               if (want.motor_duty > top_duty)
                  top_duty = want.motor_duty;
            end
         end
         // Register writes only ever come while no tick word is in flight.
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_DEBOUNCE: lim_debounce = csr_data;
               CSR_RAMP:     lim_ramp     = csr_data;
               CSR_TOP:      speed_top    = csr_data[7:0];
               CSR_GREEN:    green_angle  = csr_data[7:0];
               CSR_RIPE:     ripe_angle   = csr_data[7:0];
               default:      ;
            endcase
         end
         if (req_fire)
            expected_results.push_back(advance_belt(req_data));
      end
   end

   // Tick driver. A word stays on offer until it is taken; after a word is taken
   // a gap may follow before the next one.
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            req_data  <= pending_ticks.pop_front();
            req_valid <= 1'b1;
            if (req_idle_on && $urandom_range(0, 99) < 20)
               req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver. Besides the short random stalls it holds off once for a long
   // stretch, so that the result register stays full and the tick stream backs up.
   always @(negedge clock) begin
      if (pressure_start && !pressure_done) begin
         hold_left     = PRESSURE_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_idle_on && $urandom_range(0, 99) < 20)
            rsp_stall = pick_gap();
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes all five registers and one unused index, and sizes the quiet stretches
   // so that a full ramp fits into one of them where that is practical.
   task automatic set_limits(input logic [15:0] debounce, input logic [15:0] ramp,
                             input logic [15:0] top, input logic [15:0] green,
                             input logic [15:0] ripe);
      int unsigned span;
      write_register(CSR_DEBOUNCE, debounce);
      write_register(CSR_RAMP, ramp);
      write_register(CSR_TOP, top);
      write_register(CSR_GREEN, green);
      write_register(CSR_RIPE, ripe);
      write_register(CSR_INDEX_BITS'($urandom_range(CSR_SPARE_LOW, CSR_SPARE_HIGH)),
                     CSR_DATA_BITS'($urandom_range(0, 65535)));
      span      = int'(top[7:0]) * (int'(ramp) + 1) + 3;
      idle_span = (span > IDLE_SPAN_CAP) ? IDLE_SPAN_CAP : span;
   endtask

   // Waits until every tick word has been taken and answered, then a little longer.
   task automatic drain_belt();
      while (pending_ticks.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic queue_tick(input req_type t);
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   // A tick with no emergency and no serial byte, the buttons at their held levels.
   // The unused serial byte carries random bits all the same.
   function automatic req_type quiet_tick();
      req_type t;
      t              = '0;
      t.serial_byte  = 8'($urandom_range(0, 255));
      {t.btn_green, t.btn_ripe, t.btn_brake, t.btn_start} = held_levels;
      return t;
   endfunction

   task automatic queue_serial(input logic [7:0] code);
      req_type t;
      t              = quiet_tick();
      t.serial_valid = 1'b1;
      t.serial_byte  = code;
      queue_tick(t);
   endtask

   // Random traffic built from short well-formed actions: quiet stretches for the
   // ramp to run, serial commands, button presses with release, and a little noise.
   task automatic queue_traffic(input int unsigned count);
      int unsigned made;
      int unsigned pick;
      int unsigned len;
      int unsigned k;
      req_type     t;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            len = $urandom_range(1, idle_span);
            repeat (len) queue_tick(quiet_tick());
            made += len;
         end else if (pick < 55) begin
            case ($urandom_range(0, 9))
               0, 1, 2: queue_serial(CMD_START);
               3, 4:    queue_serial(CMD_BRAKE);
               5, 6:    queue_serial(CMD_RIPE);
               7, 8:    queue_serial(CMD_GREEN);
               default: queue_serial(CMD_STOP);
            endcase
            made++;
         end else if (pick < 80) begin
            len = $urandom_range(1, 3);
            k   = $urandom_range(0, 3);
            held_levels[k] = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
               k = $urandom_range(0, 3);
               held_levels[k] = 1'b0;
            end
            repeat (len) queue_tick(quiet_tick());
            held_levels = '1;
            queue_tick(quiet_tick());
            made += len + 1;
         end else if (pick < 83) begin
            t              = quiet_tick();
            t.emergency    = 1'b1;
            t.serial_valid = 1'($urandom_range(0, 1));
            queue_tick(t);
            made++;
         end else begin
            t           = req_type'($urandom);
            t.emergency = ($urandom_range(0, 7) == 0);
            queue_tick(t);
            made++;
         end
      end
   endtask

   initial begin
      req_type     t;
      int unsigned random_base;
      logic [15:0] pick_debounce;
      logic [15:0] pick_ramp;
      logic [15:0] pick_top;
      logic [15:0] pick_green;
      logic [15:0] pick_ripe;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The first two ticks run on the reset values: a button press
      // this early falls inside the lockout and must be ignored.
      queue_tick(quiet_tick());
      held_levels = 4'b1110;
      queue_tick(quiet_tick());
      held_levels = '1;
      drain_belt();

      // No lockout, a step every tick and a ramp of two, so each command shows at once.
      set_limits(16'd0, 16'd0, 16'd2, 16'd180, 16'd0);
      queue_serial(CMD_RIPE);    // ignored while waiting
      queue_serial(CMD_BRAKE);   // ignored while waiting
      queue_serial(CMD_START);
      queue_tick(quiet_tick());
      queue_tick(quiet_tick());  // top reached, operating from here
      queue_serial(CMD_RIPE);
      held_levels = 4'b0111;     // green button falls
      queue_tick(quiet_tick());
      held_levels = 4'b0100;     // start and brake fall together, start has priority
      queue_tick(quiet_tick());
      held_levels = '1;
      queue_tick(quiet_tick());
      // A serial byte hides a pressed button, which is then seen on the next tick.
      held_levels = 4'b1011;
      queue_serial(CMD_BRAKE);
      queue_tick(quiet_tick());
      held_levels = '1;
      queue_tick(quiet_tick());
      // An emergency drops its serial byte, so the brake button is sampled instead.
      held_levels    = 4'b1101;
      t              = quiet_tick();
      t.emergency    = 1'b1;
      t.serial_valid = 1'b1;
      t.serial_byte  = CMD_START;
      queue_tick(t);
      held_levels = '1;
      queue_serial(CMD_START);
      queue_serial(CMD_STOP);
      queue_serial(CMD_START);
      t           = quiet_tick();
      t.emergency = 1'b1;
      queue_tick(t);
      queue_serial(8'hFF);       // not a command character
      queue_serial(CMD_NONE);
      drain_belt();

      // Random part. The first three settings are fixed: the narrowest limits, then a
      // full-scale ramp, then a top speed of zero that usually lands under the speed
      // the previous setting left behind.
      random_base = ticks_queued;
      set_limits(16'd0, 16'd0, 16'd1, 16'd180, 16'd0);
      queue_traffic(150);
      drain_belt();

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      set_limits(16'd1, 16'd0, 16'd255, 16'd0, 16'd180);
      queue_traffic(350);
      pressure_start = 1'b1;
      drain_belt();

      set_limits(16'd3, 16'd2, 16'd0, 16'($urandom_range(0, 180)),
                 16'($urandom_range(0, 180)));
      queue_traffic(150);
      drain_belt();

      while (ticks_queued - random_base < RANDOM_TICKS) begin
         req_idle_on   = ($urandom_range(0, 3) != 0);
         rsp_idle_on   = ($urandom_range(0, 3) != 0);
         pick_debounce = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(10, 80))
                                                     : 16'($urandom_range(0, 4));
         pick_ramp     = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(4, 12))
                                                     : 16'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       pick_top = 16'd0;
            1:       pick_top = 16'd255;
            2:       pick_top = 16'($urandom_range(0, 65535));
            default: pick_top = 16'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       pick_green = 16'($urandom_range(0, 65535));
            1:       pick_green = 16'($urandom_range(181, 255));
            default: pick_green = 16'($urandom_range(0, 180));
         endcase
         case ($urandom_range(0, 5))
            0:       pick_ripe = 16'($urandom_range(0, 65535));
            1:       pick_ripe = 16'($urandom_range(181, 255));
            default: pick_ripe = 16'($urandom_range(0, 180));
         endcase
         set_limits(pick_debounce, pick_ramp, pick_top, pick_green, pick_ripe);
         queue_traffic($urandom_range(150, 250));
         drain_belt();
      end

      $display("Sent %0d tick words and checked %0d result words across %0d register writes.",
               ticks_queued, results_checked, csr_writes);
      $display("Run states seen %b, button commands taken %0d, highest duty %0d.",
               states_seen, events_taken, top_duty);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin
      #15_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
